### sv/seg_isect_pkg.sv
// shared types and constants for the segment intersection pipeline
// no dependencies; used by segment_intersection and its testbench
package seg_isect_pkg;

  // result codes
  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_e;

  // register byte address bit that selects beyond the register list
  localparam int RegSelBit = 2;
  localparam logic RegThreshold = 1'b0;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_end_x;
    logic signed [31:0] a_end_y;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_end_x;
    logic signed [31:0] b_end_y;
  } in_beat_t;

  typedef struct packed {
    logic               hit;
    status_e            status;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } out_beat_t;

endpackage

### sv/segment_intersection.sv
// 2d segment intersection: exact determinant, inside test, pipelined lerp divide
// depends on seg_isect_pkg
// throughput: one beat per cycle while the skid stage is empty; the divide is COORD_BITS restoring stages, one bit each
// a skid stage at the output keeps input stall registered; a full skid stage holds the pipe
// reset clears all valid bits and loads the threshold register thr_q with round(2^(2*FRAC_BITS)/1e6)
module segment_intersection #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  seg_isect_pkg::in_beat_t in_beat_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output seg_isect_pkg::out_beat_t out_beat_o,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;       // coordinate differences
  localparam int PW  = 2 * DW;       // signed products
  localparam int DTW = 2 * CB + 3;   // determinant and numerators, signed
  localparam int MW  = 2 * CB + 2;   // magnitude of determinant / accepted t numerator
  localparam int HW  = CB + 1;       // split point of the wide multiply
  localparam int LPW = HW + CB;      // partial product width
  localparam int NW  = 3 * CB + 2;   // lerp numerator
  localparam logic [63:0] ThrReset64 =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
  localparam logic [31:0] ThrReset = ThrReset64[31:0];

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  logic [31:0] thr_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr && (paddr[seg_isect_pkg::RegSelBit] == seg_isect_pkg::RegThreshold)) begin
      thr_q <= pwdata;
    end
  end

  assign prdata = (paddr[seg_isect_pkg::RegSelBit] == seg_isect_pkg::RegThreshold) ?
                  thr_q : 32'd0;

  // ---------------------------------------------------------------------------
  // pipeline advance: whole pipe moves while the skid stage is empty
  // ---------------------------------------------------------------------------
  logic skid_v_q;
  logic en;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---------------------------------------------------------------------------
  // stage 1: coordinate differences
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  assign ax0 = in_beat_i.a_start_x[CB-1:0];
  assign ay0 = in_beat_i.a_start_y[CB-1:0];
  assign ax1 = in_beat_i.a_end_x[CB-1:0];
  assign ay1 = in_beat_i.a_end_y[CB-1:0];
  assign bx0 = in_beat_i.b_start_x[CB-1:0];
  assign by0 = in_beat_i.b_start_y[CB-1:0];
  assign bx1 = in_beat_i.b_end_x[CB-1:0];
  assign by1 = in_beat_i.b_end_y[CB-1:0];

  logic                 v1_q;
  logic signed [DW-1:0] dax1_q, day1_q, dbx1_q, dby1_q, sx1_q, sy1_q, delx1_q, dely1_q;
  logic signed [CB-1:0] ax1_q, ay1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // operands are sign-extended by one bit so the differences are exact
      dax1_q  <= DW'(ax0) - DW'(ax1);
      day1_q  <= DW'(ay0) - DW'(ay1);
      dbx1_q  <= DW'(bx0) - DW'(bx1);
      dby1_q  <= DW'(by0) - DW'(by1);
      sx1_q   <= DW'(ax0) - DW'(bx0);
      sy1_q   <= DW'(ay0) - DW'(by0);
      delx1_q <= DW'(ax1) - DW'(ax0);
      dely1_q <= DW'(ay1) - DW'(ay0);
      ax1_q   <= ax0;
      ay1_q   <= ay0;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: six cross products
  // ---------------------------------------------------------------------------
  logic                 v2_q;
  logic signed [PW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [DW-1:0] delx2_q, dely2_q;
  logic signed [CB-1:0] ax2_q, ay2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_q    <= dax1_q * dby1_q;
      m1_q    <= day1_q * dbx1_q;
      m2_q    <= sx1_q * dby1_q;
      m3_q    <= sy1_q * dbx1_q;
      m4_q    <= sx1_q * day1_q;
      m5_q    <= sy1_q * dax1_q;
      delx2_q <= delx1_q;
      dely2_q <= dely1_q;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: determinant and t, u numerators
  // ---------------------------------------------------------------------------
  logic                  v3_q;
  logic signed [DTW-1:0] d3_q, tn3_q, un3_q;
  logic signed [DW-1:0]  delx3_q, dely3_q;
  logic signed [CB-1:0]  ax3_q, ay3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q    <= DTW'(m0_q) - DTW'(m1_q);
      tn3_q   <= DTW'(m2_q) - DTW'(m3_q);
      un3_q   <= DTW'(m4_q) - DTW'(m5_q);
      delx3_q <= delx2_q;
      dely3_q <= dely2_q;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: make the determinant non-negative, split deltas into sign and size
  // ---------------------------------------------------------------------------
  logic                  v4_q;
  logic signed [DTW-1:0] d4_q, tn4_q, un4_q;
  logic [1:0]            neg4_q;
  logic [CB-1:0]         magx4_q, magy4_q;
  logic signed [CB-1:0]  ax4_q, ay4_q;
  logic signed [DW-1:0]  delx_abs, dely_abs;

  assign delx_abs = delx3_q[DW-1] ? -delx3_q : delx3_q;
  assign dely_abs = dely3_q[DW-1] ? -dely3_q : dely3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d4_q    <= d3_q[DTW-1] ? -d3_q  : d3_q;
      tn4_q   <= d3_q[DTW-1] ? -tn3_q : tn3_q;
      un4_q   <= d3_q[DTW-1] ? -un3_q : un3_q;
      neg4_q  <= {dely3_q[DW-1], delx3_q[DW-1]};
      // a delta magnitude never exceeds 2^CB - 1
      magx4_q <= delx_abs[CB-1:0];
      magy4_q <= dely_abs[CB-1:0];
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: parallel / outside classification, no division
  // ---------------------------------------------------------------------------
  logic signed [DTW-1:0] thr_ext;
  logic                  is_par, is_out;
  seg_isect_pkg::status_e st5_d;

  assign thr_ext = $signed({{(DTW-32){1'b0}}, thr_q});
  // zero determinant is parallel even with a zero threshold
  assign is_par  = (d4_q == '0) || (d4_q < thr_ext);
  assign is_out  = tn4_q[DTW-1] || (tn4_q > d4_q) || un4_q[DTW-1] || (un4_q > d4_q);

  always_comb begin
    if (is_par) begin
      st5_d = seg_isect_pkg::ST_PARALLEL;
    end else if (is_out) begin
      st5_d = seg_isect_pkg::ST_OUTSIDE;
    end else begin
      st5_d = seg_isect_pkg::ST_HIT;
    end
  end

  logic                   v5_q;
  seg_isect_pkg::status_e st5_q;
  logic [MW-1:0]          d5_q, tn5_q;
  logic [1:0]             neg5_q;
  logic [CB-1:0]          magx5_q, magy5_q;
  logic signed [CB-1:0]   ax5_q, ay5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      st5_q   <= st5_d;
      d5_q    <= d4_q[MW-1:0];
      // only meaningful on a hit, where 0 <= tn <= d
      tn5_q   <= tn4_q[MW-1:0];
      neg5_q  <= neg4_q;
      magx5_q <= magx4_q;
      magy5_q <= magy4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: tn * |delta| as two partial products per lane
  // ---------------------------------------------------------------------------
  logic                   v6_q;
  logic [LPW-1:0]         plx6_q, phx6_q, ply6_q, phy6_q;
  seg_isect_pkg::status_e st6_q;
  logic [MW-1:0]          d6_q;
  logic [1:0]             neg6_q;
  logic signed [CB-1:0]   ax6_q, ay6_q;
  logic [HW-1:0]          tn_lo, tn_hi;

  assign tn_lo = tn5_q[HW-1:0];
  assign tn_hi = tn5_q[MW-1:HW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      plx6_q <= LPW'(tn_lo) * LPW'(magx5_q);
      phx6_q <= LPW'(tn_hi) * LPW'(magx5_q);
      ply6_q <= LPW'(tn_lo) * LPW'(magy5_q);
      phy6_q <= LPW'(tn_hi) * LPW'(magy5_q);
      st6_q  <= st5_q;
      d6_q   <= d5_q;
      neg6_q <= neg5_q;
      ax6_q  <= ax5_q;
      ay6_q  <= ay5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7 (divider row 0): sum partials, load the divider
  // the quotient is at most |delta| < 2^CB, so the top of the numerator is below d
  // ---------------------------------------------------------------------------
  logic [NW-1:0] numx, numy;
  assign numx = NW'(plx6_q) + (NW'(phx6_q) << HW);
  assign numy = NW'(ply6_q) + (NW'(phy6_q) << HW);

  logic                   dv_q   [CB+1];
  logic [MW-1:0]          rem_q  [CB+1][2];
  logic [CB-1:0]          plo_q  [CB+1][2];
  logic [CB-1:0]          quo_q  [CB+1][2];
  logic [MW-1:0]          dd_q   [CB+1];
  seg_isect_pkg::status_e dst_q  [CB+1];
  logic [1:0]             dneg_q [CB+1];
  logic signed [CB-1:0]   da0_q  [CB+1][2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0][0]  <= numx[NW-1:CB];
      rem_q[0][1]  <= numy[NW-1:CB];
      plo_q[0][0]  <= numx[CB-1:0];
      plo_q[0][1]  <= numy[CB-1:0];
      quo_q[0][0]  <= '0;
      quo_q[0][1]  <= '0;
      dd_q[0]      <= d6_q;
      dst_q[0]     <= st6_q;
      dneg_q[0]    <= neg6_q;
      da0_q[0][0]  <= ax6_q;
      da0_q[0][1]  <= ay6_q;
    end
  end

  // restoring divide, one quotient bit per stage, x and y lanes side by side
  for (genvar k = 1; k <= CB; k++) begin : g_div
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [MW:0] trial, diff;
      logic        ge;

      assign trial = {rem_q[k-1][l], plo_q[k-1][l][CB-1]};
      assign diff  = trial - {1'b0, dd_q[k-1]};
      assign ge    = (trial >= {1'b0, dd_q[k-1]});

      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[k][l] <= ge ? diff[MW-1:0] : trial[MW-1:0];
          plo_q[k][l] <= {plo_q[k-1][l][CB-2:0], 1'b0};
          quo_q[k][l] <= {quo_q[k-1][l][CB-2:0], ge};
          da0_q[k][l] <= da0_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dd_q[k]   <= dd_q[k-1];
        dst_q[k]  <= dst_q[k-1];
        dneg_q[k] <= dneg_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // valid bits, moving with the data
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      for (int i = 0; i <= CB; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      dv_q[0] <= v6_q;
      for (int i = 1; i <= CB; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // final add: point = a0 +/- quotient, zero on anything but a hit
  // ---------------------------------------------------------------------------
  seg_isect_pkg::out_beat_t res_d;
  logic [31:0] ptx, pty;
  logic        res_hit;

  assign res_hit = (dst_q[CB] == seg_isect_pkg::ST_HIT);
  assign ptx = dneg_q[CB][0] ? (32'(da0_q[CB][0]) - 32'(quo_q[CB][0]))
                             : (32'(da0_q[CB][0]) + 32'(quo_q[CB][0]));
  assign pty = dneg_q[CB][1] ? (32'(da0_q[CB][1]) - 32'(quo_q[CB][1]))
                             : (32'(da0_q[CB][1]) + 32'(quo_q[CB][1]));

  always_comb begin
    res_d.hit     = res_hit;
    res_d.status  = dst_q[CB];
    res_d.point_x = res_hit ? $signed(ptx) : '0;
    res_d.point_y = res_hit ? $signed(pty) : '0;
  end

  // ---------------------------------------------------------------------------
  // output register plus skid stage
  // ---------------------------------------------------------------------------
  logic                     out_v_q;
  seg_isect_pkg::out_beat_t out_q, skid_q;
  logic                     up_take, out_take;

  assign up_take  = en && dv_q[CB];
  assign out_take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (up_take) begin
      if (!out_v_q || out_take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_take) begin
      if (!out_v_q || out_take) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end else if (out_take && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_beat_o  = out_q;

endmodule

### tb/tb_segment_intersection.sv
`timescale 1ns / 1ps
// testbench for segment_intersection: drives segment pairs and register writes,
// predicts each result in exact integer arithmetic; depends on seg_isect_pkg
module tb_segment_intersection;

  // expected results kept in order, compared beat by beat
  class isect_scoreboard;
    seg_isect_pkg::out_beat_t pending[$];
    logic [31:0] threshold;
    int errors;

    function new();
      threshold = 32'd4295;
      errors = 0;
    endfunction

    // exact intersection prediction for one pair of segments
    function seg_isect_pkg::out_beat_t predict(seg_isect_pkg::in_beat_t b);
      seg_isect_pkg::out_beat_t r;
      logic signed [66:0] det, tn, un;
      logic signed [33:0] dax, day, dbx, dby, sx, sy, ddx, ddy;
      logic signed [127:0] num, q;
      dax = 34'(b.a_start_x) - 34'(b.a_end_x);
      day = 34'(b.a_start_y) - 34'(b.a_end_y);
      dbx = 34'(b.b_start_x) - 34'(b.b_end_x);
      dby = 34'(b.b_start_y) - 34'(b.b_end_y);
      sx = 34'(b.a_start_x) - 34'(b.b_start_x);
      sy = 34'(b.a_start_y) - 34'(b.b_start_y);
      det = 67'(dax) * 67'(dby) - 67'(day) * 67'(dbx);
      tn = 67'(sx) * 67'(dby) - 67'(sy) * 67'(dbx);
      un = 67'(sx) * 67'(day) - 67'(sy) * 67'(dax);
      if (det < 0) begin
        det = -det;
        tn = -tn;
        un = -un;
      end
      r = '0;
      if (det == 0 || det < $signed({35'd0, threshold})) begin
        r.status = seg_isect_pkg::ST_PARALLEL;
      end else if (tn < 0 || tn > det || un < 0 || un > det) begin
        r.status = seg_isect_pkg::ST_OUTSIDE;
      end else begin
        r.hit = 1'b1;
        r.status = seg_isect_pkg::ST_HIT;
        ddx = 34'(b.a_end_x) - 34'(b.a_start_x);
        ddy = 34'(b.a_end_y) - 34'(b.a_start_y);
        // signed division truncates toward zero, as the block does
        num = 128'(tn) * 128'(ddx);
        q = num / 128'(det);
        r.point_x = b.a_start_x + q[31:0];
        num = 128'(tn) * 128'(ddy);
        q = num / 128'(det);
        r.point_y = b.a_start_y + q[31:0];
      end
      return r;
    endfunction

    function void note_pair(seg_isect_pkg::in_beat_t b);
      pending.push_back(predict(b));
    endfunction

    function void check_result(seg_isect_pkg::out_beat_t got);
      seg_isect_pkg::out_beat_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.hit !== exp_r.hit || got.status !== exp_r.status ||
          got.point_x !== exp_r.point_x || got.point_y !== exp_r.point_y) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp hit=%0b st=%0d x=%h y=%h got hit=%0b st=%0d x=%h y=%h",
                   exp_r.hit, exp_r.status, exp_r.point_x, exp_r.point_y,
                   got.hit, got.status, got.point_x, got.point_y);
      end
    endfunction
  endclass

  localparam int LATENCY = 40;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  seg_isect_pkg::in_beat_t in_beat_i;
  seg_isect_pkg::out_beat_t out_beat_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  isect_scoreboard sb;
  bit hold_off;      // long receiver hold-off requested
  bit stall_on;      // random receiver stalls enabled

  segment_intersection u_top (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // generous limit well above the slowest correct run
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // result side: check every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_beat_o);
  end

  // receiver stall pattern: random runs, quiet stretches, one long hold-off
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end else if (stall_on) begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
      if ($urandom_range(0, 200) == 0) stall_on = !stall_on;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[seg_isect_pkg::RegSelBit] == seg_isect_pkg::RegThreshold) sb.threshold = val;
  endtask

  // offer one pair, keep valid high until accepted
  task automatic send_pair(input seg_isect_pkg::in_beat_t b);
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pair(b);
  endtask

  task automatic gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // wait until every expected result is back, then let the pipe drain
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  // random segment pairs: from mode 3 up b goes through a's midpoint, mode 2 sometimes makes b parallel to a
  function automatic seg_isect_pkg::in_beat_t rnd_pair();
    seg_isect_pkg::in_beat_t b;
    int mode;
    mode = $urandom_range(0, 5);
    b.a_start_x = rnd_coord(mode);
    b.a_start_y = rnd_coord(mode);
    b.a_end_x = rnd_coord(mode);
    b.a_end_y = rnd_coord(mode);
    b.b_start_x = rnd_coord(mode);
    b.b_start_y = rnd_coord(mode);
    b.b_end_x = rnd_coord(mode);
    b.b_end_y = rnd_coord(mode);
    if (mode >= 3) begin
      // reflect b's start through a's midpoint so many pairs cross
      b.b_end_x = b.a_start_x + b.a_end_x - b.b_start_x;
      b.b_end_y = b.a_start_y + b.a_end_y - b.b_start_y;
    end else if (mode == 2 && $urandom_range(0, 3) == 0) begin
      // parallel copy of a
      b.b_end_x = b.b_start_x + (b.a_end_x - b.a_start_x);
      b.b_end_y = b.b_start_y + (b.a_end_y - b.a_start_y);
    end
    return b;
  endfunction

  function automatic seg_isect_pkg::in_beat_t mk(int ax0, ay0, ax1, ay1,
                                                 bx0, by0, bx1, by1);
    seg_isect_pkg::in_beat_t b;
    b.a_start_x = ax0 <<< 16;
    b.a_start_y = ay0 <<< 16;
    b.a_end_x = ax1 <<< 16;
    b.a_end_y = ay1 <<< 16;
    b.b_start_x = bx0 <<< 16;
    b.b_start_y = by0 <<< 16;
    b.b_end_x = bx1 <<< 16;
    b.b_end_y = by1 <<< 16;
    return b;
  endfunction

  task automatic random_phase(input int count, input bit pressure);
    int sent, burst;
    bit pressed;
    sent = 0;
    pressed = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      if (pressure && !pressed && sent >= 20) begin
        hold_off = 1;
        pressed = 1;
      end
      for (int i = 0; i < burst && sent < count; i++) begin
        send_pair(rnd_pair());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
    drain();
  endtask

  initial begin
    seg_isect_pkg::in_beat_t b;
    sb = new();
    hold_off = 0;
    stall_on = 1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: crossing, endpoint contact, parallel, collinear, zero-length, outside, extremes
    send_pair(mk(0, 0, 4, 4, 0, 4, 4, 0));
    send_pair(mk(0, 0, 4, 0, 4, 0, 4, 5));
    send_pair(mk(0, 0, 4, 0, 0, 0, 0, -3));
    send_pair(mk(0, 0, 4, 0, 0, 1, 4, 1));
    send_pair(mk(0, 0, 4, 0, 1, 0, 6, 0));
    send_pair(mk(1, 1, 1, 1, 0, 0, 3, 2));
    send_pair(mk(0, 0, 4, 4, 5, 0, 9, -4));
    send_pair(mk(0, 0, 4, 4, 0, 9, 2, 8));
    send_pair(mk(-3, 7, 5, -1, -2, -6, 1, 8));
    b = '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
    send_pair(b);
    b = '{32'hffffffff, 32'h0, 32'h1, 32'h0, 32'h0, 32'hffffffff, 32'h0, 32'h1};
    send_pair(b);
    b = '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
    send_pair(b);
    // tiny determinant near the threshold
    b = '{32'h0, 32'h0, 32'd65, 32'h0, 32'd30, 32'hffffffc0, 32'd30, 32'd66};
    send_pair(b);
    b = '{32'h0, 32'h0, 32'd66, 32'h0, 32'd30, 32'hffffffc0, 32'd30, 32'd66};
    send_pair(b);
    drain();

    random_phase(150, 1'b1);

    // zero threshold: only an exact zero determinant is parallel
    reg_write(3'd0, 32'd0);
    b = '{32'h0, 32'h0, 32'd1, 32'h0, 32'h0, 32'hffffffff, 32'h0, 32'd1};
    send_pair(b);
    send_pair(mk(0, 0, 4, 0, 1, 0, 6, 0));
    random_phase(100, 1'b0);

    // largest threshold, then a write to an unused register
    reg_write(3'd0, 32'hffffffff);
    reg_write(3'd4, 32'd5);
    random_phase(80, 1'b0);

    reg_write(3'd0, $urandom());
    random_phase(100, 1'b0);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
sv/seg_isect_pkg.sv
sv/segment_intersection.sv
tb/tb_segment_intersection.sv
